[hw/rtl/lqbc_pkg.sv]
package lqbc_pkg;

    // Field widths of the item formats
    localparam int QUAL_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
    localparam int LIMIT_W    = 8;

    // Default full scale and window
    localparam int QUALITY_MAX_DEF = 255;
    localparam int WINDOW_SIZE_DEF = 64;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEPS = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SEND_MINIMUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECV_MINIMUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LIMIT  = 2'd2;

    localparam logic [COUNT_W-1:0] SEND_MINIMUM_RESET = 7'd1;
    localparam logic [COUNT_W-1:0] RECV_MINIMUM_RESET = 7'd1;
    localparam logic [LIMIT_W-1:0] TOTAL_LIMIT_RESET  = 8'd1;

    typedef struct packed {
        logic [QUAL_W-1:0]  packet_quality;
        logic [COUNT_W-1:0] echo_count;
        logic [COUNT_W-1:0] received_count;
    } in_item_t;

    typedef struct packed {
        logic [QUAL_W-1:0] local_quality;
        logic [QUAL_W-1:0] asym_penalty;
        logic [QUAL_W-1:0] combined_quality;
        logic              bidir_ok;
    } out_item_t;

endpackage

[hw/rtl/lqbc_stream_if.sv]
interface lqbc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/link_quality_bidirectional_check.sv]
// Channel    Dir  Modport  Payload
// announce   in   sink     packet_quality, echo_count, received_count
// verdict    out  source   local_quality, asym_penalty, combined_quality,
//                          bidir_ok
// cfg        in   -        cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle while verdict.ready is high. Stages in order: front,
// local-quality divider, scale, combined-quality divider, output register;
// both dividers pipelined and restoring, two quotient bits per stage.
// Reset clears all stage valid bits and sets the three registers to 1.
// Every stage holds its item while the next one cannot take it; bubbles close up,
// so announce.ready stays high whenever verdict.ready is high.
module link_quality_bidirectional_check #(
    parameter int QUALITY_MAX = lqbc_pkg::QUALITY_MAX_DEF,
    parameter int WINDOW_SIZE = lqbc_pkg::WINDOW_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lqbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lqbc_pkg::CFG_DATA_W-1:0] cfg_data,
    lqbc_stream_if.sink                     announce,
    lqbc_stream_if.source                   verdict
);

    localparam int QW  = $clog2(QUALITY_MAX + 1);
    localparam int CW  = lqbc_pkg::COUNT_W;
    localparam int BW  = lqbc_pkg::QUAL_W;
    localparam int NW1 = QW + CW;
    localparam int SW1 = BW + 1 + QW;
    localparam int NW2 = BW + 2 * QW;
    localparam int DW2 = 2 * QW;
    localparam int XW  = (QW > BW) ? QW : BW;
    localparam logic [DW2-1:0] QMAX_SQ = DW2'(QUALITY_MAX * QUALITY_MAX);

    function automatic logic [BW-1:0] clip8(input logic [QW-1:0] v);
        logic [XW-1:0] ext;
        ext = XW'(v);
        return (ext > XW'(255)) ? '1 : ext[BW-1:0];
    endfunction

    // Configuration registers
    logic [CW-1:0]                   send_min_reg;
    logic [CW-1:0]                   recv_min_reg;
    logic [lqbc_pkg::LIMIT_W-1:0]    limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_min_reg <= lqbc_pkg::SEND_MINIMUM_RESET;
            recv_min_reg <= lqbc_pkg::RECV_MINIMUM_RESET;
            limit_reg    <= lqbc_pkg::TOTAL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lqbc_pkg::REG_SEND_MINIMUM: send_min_reg <= cfg_data[CW-1:0];
                lqbc_pkg::REG_RECV_MINIMUM: recv_min_reg <= cfg_data[CW-1:0];
                lqbc_pkg::REG_TOTAL_LIMIT:  limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: clipping, gating, penalty table, QUALITY_MAX times used count
    logic           f_valid;
    logic           f_ready;
    logic [BW-1:0]  f_pq;
    logic [CW-1:0]  f_recv;
    logic [NW1-1:0] f_num;
    logic           f_zero;
    logic [QW-1:0]  f_pen;

    lqbc_front #(
        .QUALITY_MAX (QUALITY_MAX),
        .WINDOW_SIZE (WINDOW_SIZE),
        .QW          (QW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (announce.valid),
        .in_ready       (announce.ready),
        .packet_quality (announce.data.packet_quality),
        .echo_count     (announce.data.echo_count),
        .received_count (announce.data.received_count),
        .send_minimum   (send_min_reg),
        .recv_minimum   (recv_min_reg),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_quality    (f_pq),
        .out_recv       (f_recv),
        .out_num        (f_num),
        .out_zero       (f_zero),
        .out_pen        (f_pen)
    );

    // Local quality: QUALITY_MAX * used / received
    logic           d1_valid;
    logic           d1_ready;
    logic [QW-1:0]  d1_quot;
    logic [SW1-1:0] d1_side;

    lqbc_div_pipe #(
        .NW (NW1),
        .DW (CW),
        .QW (QW),
        .SW (SW1)
    ) u_div_local (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .dividend  (f_num),
        .divisor   (f_recv),
        .in_side   ({f_pq, f_zero, f_pen}),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quotient  (d1_quot),
        .out_side  (d1_side)
    );

    // Products for the combined quality
    logic           s_valid;
    logic           s_ready;
    logic [QW-1:0]  s_local;
    logic [QW-1:0]  s_pen;
    logic [NW2-1:0] s_prod;

    lqbc_scale #(
        .QUALITY_MAX (QUALITY_MAX),
        .QW          (QW)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (d1_valid),
        .in_ready       (d1_ready),
        .packet_quality (d1_side[SW1-1 -: BW]),
        .quot           (d1_quot),
        .zero           (d1_side[QW]),
        .pen            (d1_side[QW-1:0]),
        .out_valid      (s_valid),
        .out_ready      (s_ready),
        .out_local      (s_local),
        .out_pen        (s_pen),
        .out_prod       (s_prod)
    );

    // Combined quality: product over QUALITY_MAX squared, never above 255
    logic           d2_valid;
    logic           d2_ready;
    logic [BW-1:0]  d2_quot;
    logic [DW2-1:0] d2_side;

    lqbc_div_pipe #(
        .NW (NW2),
        .DW (DW2),
        .QW (BW),
        .SW (DW2)
    ) u_div_comb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .dividend  (s_prod),
        .divisor   (QMAX_SQ),
        .in_side   ({s_local, s_pen}),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .quotient  (d2_quot),
        .out_side  (d2_side)
    );

    // Output register
    logic                o_v_reg;
    lqbc_pkg::out_item_t o_item_reg;
    lqbc_pkg::out_item_t o_item_next;

    assign d2_ready = !o_v_reg || verdict.ready;

    always_comb
    begin
        o_item_next.local_quality    = clip8(d2_side[DW2-1:QW]);
        o_item_next.asym_penalty     = clip8(d2_side[QW-1:0]);
        o_item_next.combined_quality = d2_quot;
        o_item_next.bidir_ok         = (d2_quot >= limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (d2_ready)
            o_v_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (d2_ready && d2_valid)
            o_item_reg <= o_item_next;
    end

    assign verdict.valid = o_v_reg;
    assign verdict.data  = o_item_reg;

endmodule

[hw/rtl/lqbc_div_pipe.sv]
module lqbc_div_pipe #(
    parameter int NW    = 16,
    parameter int DW    = 8,
    parameter int QW    = 8,
    parameter int SW    = 1,
    parameter int STEPS = lqbc_pkg::DIV_STEPS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] out_side
);

    localparam int NS = (QW + STEPS - 1) / STEPS;

    // Caller guarantees dividend >> QW is below the divisor, so the
    // quotient fits in QW bits and the remainder starts from the top part.
    logic          v_reg    [NS];
    logic [DW-1:0] rem_reg  [NS];
    logic [QW-1:0] lo_reg   [NS];
    logic [DW-1:0] d_reg    [NS];
    logic [SW-1:0] side_reg [NS];
    logic          rdy      [NS+1];

    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    assign quotient  = lo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

    generate
        for (genvar s = 0; s < NS; s++) begin : g_stage
            logic          v_src;
            logic [DW-1:0] rem_src;
            logic [QW-1:0] lo_src;
            logic [DW-1:0] d_src;
            logic [SW-1:0] side_src;
            logic [DW-1:0] rem_next;
            logic [QW-1:0] lo_next;
            logic [DW:0]   t;
            logic          qb;

            if (s == 0) begin : g_first
                assign v_src    = in_valid;
                assign rem_src  = DW'(dividend >> QW);
                assign lo_src   = dividend[QW-1:0];
                assign d_src    = divisor;
                assign side_src = in_side;
            end
            else begin : g_next
                assign v_src    = v_reg[s-1];
                assign rem_src  = rem_reg[s-1];
                assign lo_src   = lo_reg[s-1];
                assign d_src    = d_reg[s-1];
                assign side_src = side_reg[s-1];
            end

            assign rdy[s] = !v_reg[s] || rdy[s+1];

            // Restoring steps: dividend bits leave lo at the top, quotient
            // bits enter at the bottom.
            always_comb
            begin
                rem_next = rem_src;
                lo_next  = lo_src;
                t        = '0;
                qb       = 1'b0;
                for (int k = 0; k < STEPS; k++)
                begin
                    if (s * STEPS + k < QW)
                    begin
                        t = {rem_next, lo_next[QW-1]};
                        if (t >= {1'b0, d_src})
                        begin
                            rem_next = DW'(t - {1'b0, d_src});
                            qb       = 1'b1;
                        end
                        else
                        begin
                            rem_next = DW'(t);
                            qb       = 1'b0;
                        end
                        lo_next = (lo_next << 1) | QW'(qb);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else if (rdy[s])
                    v_reg[s] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && v_src)
                begin
                    rem_reg[s]  <= rem_next;
                    lo_reg[s]   <= lo_next;
                    d_reg[s]    <= d_src;
                    side_reg[s] <= side_src;
                end
            end
        end
    endgenerate

endmodule

[hw/rtl/lqbc_front.sv]
module lqbc_front #(
    parameter int QUALITY_MAX = lqbc_pkg::QUALITY_MAX_DEF,
    parameter int WINDOW_SIZE = lqbc_pkg::WINDOW_SIZE_DEF,
    parameter int QW          = $clog2(QUALITY_MAX + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lqbc_pkg::QUAL_W-1:0]  packet_quality,
    input  logic [lqbc_pkg::COUNT_W-1:0] echo_count,
    input  logic [lqbc_pkg::COUNT_W-1:0] received_count,
    input  logic [lqbc_pkg::COUNT_W-1:0] send_minimum,
    input  logic [lqbc_pkg::COUNT_W-1:0] recv_minimum,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lqbc_pkg::QUAL_W-1:0]  out_quality,
    output logic [lqbc_pkg::COUNT_W-1:0] out_recv,
    output logic [QW+lqbc_pkg::COUNT_W-1:0] out_num,
    output logic                         out_zero,
    output logic [QW-1:0]                out_pen
);

    localparam int CW    = lqbc_pkg::COUNT_W;
    localparam int NW    = QW + CW;
    localparam int WCLIP = (WINDOW_SIZE > lqbc_pkg::COUNT_MAX) ?
                           lqbc_pkg::COUNT_MAX : WINDOW_SIZE;
    localparam logic [CW-1:0] WIN_C = CW'(WCLIP);

    // Penalty by raw received count; clipping to the window is folded in
    logic [QW-1:0] pen_lut [lqbc_pkg::COUNT_MAX+1];

    generate
        for (genvar g = 0; g <= lqbc_pkg::COUNT_MAX; g++) begin : g_pen
            localparam longint unsigned GR  = (g > WINDOW_SIZE) ? WINDOW_SIZE : g;
            localparam longint unsigned GAP = WINDOW_SIZE - GR;
            localparam longint unsigned PV  = QUALITY_MAX -
                (QUALITY_MAX * GAP * GAP) / (WINDOW_SIZE * WINDOW_SIZE);
            assign pen_lut[g] = QW'(PV);
        end
    endgenerate

    logic                a_v_reg;
    logic [7:0]          a_pq_reg;
    logic [CW-1:0]       a_used_reg;
    logic [CW-1:0]       a_recv_reg;
    logic                a_zero_reg;
    logic [QW-1:0]       a_pen_reg;

    logic                b_v_reg;
    logic [7:0]          b_pq_reg;
    logic [CW-1:0]       b_recv_reg;
    logic [NW-1:0]       b_num_reg;
    logic                b_zero_reg;
    logic [QW-1:0]       b_pen_reg;

    logic [CW-1:0]       echo_c;
    logic [CW-1:0]       recv_c;
    logic [CW-1:0]       used;
    logic                a_zero_next;
    logic [NW-1:0]       b_num_next;
    logic                rdy_a;
    logic                rdy_b;

    assign rdy_b    = !b_v_reg || out_ready;
    assign rdy_a    = !a_v_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        echo_c      = (echo_count > WIN_C) ? WIN_C : echo_count;
        recv_c      = (received_count > WIN_C) ? WIN_C : received_count;
        used        = (echo_c > recv_c) ? recv_c : echo_c;
        a_zero_next = (recv_c == '0) || (used < send_minimum) || (recv_c < recv_minimum);
    end

    assign b_num_next = NW'(QUALITY_MAX) * NW'(a_used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_v_reg <= in_valid;
            if (rdy_b)
                b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            a_pq_reg   <= packet_quality;
            a_used_reg <= used;
            a_recv_reg <= recv_c;
            a_zero_reg <= a_zero_next;
            a_pen_reg  <= pen_lut[received_count];
        end
        if (rdy_b && a_v_reg)
        begin
            b_pq_reg   <= a_pq_reg;
            b_recv_reg <= a_recv_reg;
            b_num_reg  <= b_num_next;
            b_zero_reg <= a_zero_reg;
            b_pen_reg  <= a_pen_reg;
        end
    end

    assign out_valid   = b_v_reg;
    assign out_quality = b_pq_reg;
    assign out_recv    = b_recv_reg;
    assign out_num     = b_num_reg;
    assign out_zero    = b_zero_reg;
    assign out_pen     = b_pen_reg;

endmodule

[hw/rtl/lqbc_scale.sv]
module lqbc_scale #(
    parameter int QUALITY_MAX = lqbc_pkg::QUALITY_MAX_DEF,
    parameter int QW          = $clog2(QUALITY_MAX + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lqbc_pkg::QUAL_W-1:0]       packet_quality,
    input  logic [QW-1:0]                     quot,
    input  logic                              zero,
    input  logic [QW-1:0]                     pen,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [QW-1:0]                     out_local,
    output logic [QW-1:0]                     out_pen,
    output logic [lqbc_pkg::QUAL_W+2*QW-1:0]  out_prod
);

    localparam int PW1 = lqbc_pkg::QUAL_W + QW;
    localparam int PW2 = lqbc_pkg::QUAL_W + 2 * QW;

    logic           a_v_reg;
    logic [QW-1:0]  a_loc_reg;
    logic [QW-1:0]  a_pen_reg;
    logic [PW1-1:0] a_prod_reg;

    logic           b_v_reg;
    logic [QW-1:0]  b_loc_reg;
    logic [QW-1:0]  b_pen_reg;
    logic [PW2-1:0] b_prod_reg;

    logic [QW-1:0]  a_loc_next;
    logic [PW1-1:0] a_prod_next;
    logic [PW2-1:0] b_prod_next;
    logic           rdy_a;
    logic           rdy_b;

    assign rdy_b    = !b_v_reg || out_ready;
    assign rdy_a    = !a_v_reg || rdy_b;
    assign in_ready = rdy_a;

    // Gated local quality (too little data or nothing received)
    assign a_loc_next  = zero ? '0 : quot;
    assign a_prod_next = PW1'(packet_quality) * PW1'(a_loc_next);
    assign b_prod_next = PW2'(a_prod_reg) * PW2'(a_pen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_v_reg <= in_valid;
            if (rdy_b)
                b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            a_loc_reg  <= a_loc_next;
            a_pen_reg  <= pen;
            a_prod_reg <= a_prod_next;
        end
        if (rdy_b && a_v_reg)
        begin
            b_loc_reg  <= a_loc_reg;
            b_pen_reg  <= a_pen_reg;
            b_prod_reg <= b_prod_next;
        end
    end

    assign out_valid = b_v_reg;
    assign out_local = b_loc_reg;
    assign out_pen   = b_pen_reg;
    assign out_prod  = b_prod_reg;

endmodule

[hw/rtl/lqbc_checker.sv]
module lqbc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input lqbc_pkg::out_item_t             out_item,
    input logic                            cfg_we,
    input logic [lqbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [lqbc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Mirror of the limit register as seen from the port
    logic [lqbc_pkg::LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= lqbc_pkg::TOTAL_LIMIT_RESET;
        else if (cfg_we && cfg_index == lqbc_pkg::REG_TOTAL_LIMIT)
            limit_reg <= cfg_data;
    end

    // An offered item stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("announcement withdrawn before acceptance");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.bidir_ok ==
                      (out_item.combined_quality >= limit_reg))
        else $error("bidirectional flag disagrees with limit");

    a_zero_local: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.local_quality == '0 |-> out_item.combined_quality == '0)
        else $error("combined quality nonzero with zero local quality");

    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule

bind link_quality_bidirectional_check lqbc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (announce.valid),
    .in_ready  (announce.ready),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .out_item  (verdict.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned QMAX = lqbc_pkg::QUALITY_MAX_DEF;
    localparam longint unsigned WIN  = lqbc_pkg::WINDOW_SIZE_DEF;
    localparam int unsigned WIN_RANGE = lqbc_pkg::WINDOW_SIZE_DEF;
    localparam int unsigned CNT_RANGE = lqbc_pkg::COUNT_MAX;
    localparam int PIPE_LATENCY      = 13;
    localparam int STALL_LIMIT       = 2000;
    localparam int PHASE_ITEMS       = 180;

    // Index with no register behind it; writes must be ignored
    localparam logic [lqbc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lqbc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lqbc_pkg::CFG_DATA_W-1:0] cfg_data;

    lqbc_stream_if #(.payload_t(lqbc_pkg::in_item_t))  announce ();
    lqbc_stream_if #(.payload_t(lqbc_pkg::out_item_t)) verdict ();

    link_quality_bidirectional_check DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .announce  (announce),
        .verdict   (verdict)
    );

    // Local copy of the register file
    logic [lqbc_pkg::COUNT_W-1:0] send_floor;
    logic [lqbc_pkg::COUNT_W-1:0] recv_floor;
    logic [lqbc_pkg::LIMIT_W-1:0] bidir_limit;

    lqbc_pkg::out_item_t verdicts_due[$];
    int        announcements_sent = 0;
    int        verdicts_checked = 0;
    int        settings_used;
    int        faults = 0;
    int        stuck_cycles;
    bit        steady_flow;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic lqbc_pkg::out_item_t grade_announcement(lqbc_pkg::in_item_t a);
        longint unsigned echo, recv, used, lq, gap, penalty, combined;
        lqbc_pkg::out_item_t g;
        echo = (a.echo_count > WIN) ? WIN : a.echo_count;
        recv = (a.received_count > WIN) ? WIN : a.received_count;
        used = (echo > recv) ? recv : echo;
        if (recv == 0 || used < send_floor || recv < recv_floor)
            lq = 0;
        else
            lq = (QMAX * used) / recv;
        gap      = WIN - recv;
        penalty  = QMAX - (QMAX * gap * gap) / (WIN * WIN);
        combined = (a.packet_quality * lq * penalty) / (QMAX * QMAX);
        if (combined > 255)
            combined = 255;
        g.local_quality    = (lq > 255) ? 8'd255 : lq[7:0];
        g.asym_penalty     = (penalty > 255) ? 8'd255 : penalty[7:0];
        g.combined_quality = combined[7:0];
        g.bidir_ok         = (combined >= bidir_limit);
        return g;
    endfunction

    // Mostly no pause, sometimes a short one, rarely a long one
    function automatic int idle_span();
        int unsigned r;
        r = $urandom_range(99);
        if (steady_flow || r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic lqbc_pkg::in_item_t random_announcement();
        lqbc_pkg::in_item_t a;
        int unsigned shape;
        int unsigned recv;
        int unsigned echo;
        shape = $urandom_range(99);
        recv  = (shape < 85) ? $urandom_range(WIN_RANGE) : $urandom_range(CNT_RANGE);
        a.received_count = recv[lqbc_pkg::COUNT_W-1:0];
        if (shape < 65)
            echo = $urandom_range((recv > WIN_RANGE) ? WIN_RANGE : recv);
        else
            echo = $urandom_range(CNT_RANGE);
        a.echo_count = echo[lqbc_pkg::COUNT_W-1:0];
        case ($urandom_range(9))
            0:       a.packet_quality = 8'd255;
            1:       a.packet_quality = 8'd0;
            default: a.packet_quality = 8'($urandom_range(255));
        endcase
        return a;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_announcement(input logic [lqbc_pkg::QUAL_W-1:0] pq,
                                     input logic [lqbc_pkg::COUNT_W-1:0] echo,
                                     input logic [lqbc_pkg::COUNT_W-1:0] recv);
        int gap;
        gap = idle_span();
        if (gap > 0)
        begin
            announce.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        announce.valid <= 1'b1;
        announce.data  <= '{packet_quality: pq, echo_count: echo, received_count: recv};
        do
            @(posedge clk);
        while (!announce.ready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        lqbc_pkg::in_item_t a;
        repeat (count)
        begin
            a = random_announcement();
            send_announcement(a.packet_quality, a.echo_count, a.received_count);
        end
    endtask

    // Returns at a falling edge with nothing in flight
    task automatic wait_drained();
        announce.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [lqbc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lqbc_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            lqbc_pkg::REG_SEND_MINIMUM: send_floor  = value[lqbc_pkg::COUNT_W-1:0];
            lqbc_pkg::REG_RECV_MINIMUM: recv_floor  = value[lqbc_pkg::COUNT_W-1:0];
            lqbc_pkg::REG_TOTAL_LIMIT:  bidir_limit = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [lqbc_pkg::CFG_DATA_W-1:0] send_min,
                                 input logic [lqbc_pkg::CFG_DATA_W-1:0] recv_min,
                                 input logic [lqbc_pkg::CFG_DATA_W-1:0] limit);
        wait_drained();
        write_register(lqbc_pkg::REG_SEND_MINIMUM, send_min);
        write_register(lqbc_pkg::REG_RECV_MINIMUM, recv_min);
        write_register(lqbc_pkg::REG_TOTAL_LIMIT, limit);
        settings_used++;
    endtask

    // Reset register values: both minimums and the limit at one
    task automatic test_field_extremes();
        send_announcement(8'd0,   7'd0,   7'd0);
        send_announcement(8'd255, 7'd127, 7'd127);
        send_announcement(8'd255, 7'd64,  7'd64);
        send_announcement(8'd255, 7'd65,  7'd65);
        send_announcement(8'd255, 7'd0,   7'd64);
        send_announcement(8'd200, 7'd64,  7'd32);
        send_announcement(8'd200, 7'd127, 7'd1);
        send_announcement(8'd255, 7'd1,   7'd1);
        send_announcement(8'd255, 7'd64,  7'd0);
        send_announcement(8'd128, 7'd63,  7'd63);
        send_announcement(8'd85,  7'd42,  7'd127);
        send_announcement(8'd1,   7'd1,   7'd64);
    endtask

    task automatic test_minimum_registers();
        apply_setting(8'd10, 8'd20, 8'd0);
        send_announcement(8'd255, 7'd9,  7'd30);
        send_announcement(8'd255, 7'd10, 7'd19);
        send_announcement(8'd255, 7'd10, 7'd20);
        send_announcement(8'd0,   7'd0,  7'd0);
        apply_setting(8'd0, 8'd0, 8'd255);
        send_announcement(8'd255, 7'd0,  7'd0);
        send_announcement(8'd255, 7'd0,  7'd10);
        send_announcement(8'd255, 7'd64, 7'd64);
        // upper bit of the data dropped: minimums of 127 lie beyond the window
        apply_setting(8'hFF, 8'hFF, 8'd1);
        send_announcement(8'd255, 7'd127, 7'd127);
        wait_drained();
        write_register(REG_UNMAPPED, 8'h00);
        send_announcement(8'd255, 7'd64, 7'd64);
    endtask

    task automatic test_random_settings();
        apply_setting(8'd1, 8'd1, 8'd1);
        send_random(PHASE_ITEMS);
        apply_setting(8'd0, 8'd0, 8'd0);
        send_random(PHASE_ITEMS);
        apply_setting(8'd64, 8'd64, 8'd255);
        send_random(PHASE_ITEMS);
        repeat (5)
        begin
            apply_setting(8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                       : $urandom_range(16)),
                          8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                       : $urandom_range(16)),
                          8'($urandom_range(255)));
            send_random(PHASE_ITEMS);
        end
    endtask

    task automatic test_back_to_back();
        apply_setting(8'd2, 8'd4, 8'd40);
        steady_flow = 1'b1;
        send_random(150);
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // Result sink with random back-pressure
    initial
    begin
        int hold;
        hold = 0;
        verdict.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady_flow)
            begin
                hold = 0;
                verdict.ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                verdict.ready <= 1'b0;
            end
            else
            begin
                verdict.ready <= 1'b1;
                hold = idle_span();
            end
        end
    end

    always @(posedge clk)
    begin
        lqbc_pkg::out_item_t want;
        lqbc_pkg::out_item_t got;
        if (rst_n && verdict.valid && verdict.ready)
        begin
            got = verdict.data;
            if (verdicts_due.size() == 0)
            begin
                $error("verdict with no announcement outstanding");
                faults++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                verdicts_checked++;
                if (got.local_quality !== want.local_quality)
                begin
                    $error("local_quality: expected %0d, got %0d",
                           want.local_quality, got.local_quality);
                    faults++;
                end
                if (got.asym_penalty !== want.asym_penalty)
                begin
                    $error("asym_penalty: expected %0d, got %0d",
                           want.asym_penalty, got.asym_penalty);
                    faults++;
                end
                if (got.combined_quality !== want.combined_quality)
                begin
                    $error("combined_quality: expected %0d, got %0d",
                           want.combined_quality, got.combined_quality);
                    faults++;
                end
                if (got.bidir_ok !== want.bidir_ok)
                begin
                    $error("bidir_ok: expected %0d, got %0d",
                           want.bidir_ok, got.bidir_ok);
                    faults++;
                end
            end
        end
        if (rst_n && announce.valid && announce.ready)
        begin
            verdicts_due.push_back(grade_announcement(announce.data));
            announcements_sent++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (announce.valid && announce.ready) || (verdict.valid && verdict.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("handshake stalled for %0d cycles", stuck_cycles);
            $display("FAIL link_quality_bidirectional_check");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        announce.valid     = 1'b0;
        announce.data      = '0;
        steady_flow        = 1'b0;
        settings_used      = 1;
        send_floor         = lqbc_pkg::SEND_MINIMUM_RESET;
        recv_floor         = lqbc_pkg::RECV_MINIMUM_RESET;
        bidir_limit        = lqbc_pkg::TOTAL_LIMIT_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_minimum_registers();
        test_random_settings();
        test_back_to_back();
        wait_drained();

        $display("%0d announcements graded under %0d register settings, %0d verdicts checked",
                 announcements_sent, settings_used, verdicts_checked);
        $display("counts past the window, echo above received and minimums beyond window covered");
        if (faults == 0)
            $display("PASS link_quality_bidirectional_check");
        else
            $display("FAIL link_quality_bidirectional_check");
        $finish;
    end

endmodule
